/* hw/rtl/sfqm_pkg.sv */
`timescale 1ns / 1ps

package sfqm_pkg;

  // Default sizes
  localparam int TAPS_DEF          = 12;
  localparam int QUARTER_DELAY_DEF = 3;
  localparam int SAMPLE_BITS_DEF   = 12;

  // Fixed field widths
  localparam int FILT_BITS = 14;
  localparam int MAG_BITS  = 13;
  localparam int MASK_BITS = 12;

  localparam logic [MASK_BITS-1:0] MASK_RESET = MASK_BITS'(504);

  localparam int FILT_MAX = (1 << (FILT_BITS - 1)) - 1;
  localparam int FILT_MIN = -(1 << (FILT_BITS - 1));
  localparam int MAG_MAX  = (1 << MAG_BITS) - 1;

  // Square root sizing: radicand holds two squared filtered values
  localparam int SQ_BITS    = 2 * FILT_BITS;
  localparam int ROOT_BITS  = SQ_BITS / 2;
  localparam int ROOT_STEPS = ROOT_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One queued transaction: current and quarter-cycle-old filtered values
  typedef struct packed {
    logic signed [FILT_BITS-1:0] cur;
    logic signed [FILT_BITS-1:0] old;
  } q_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/sfqm_front.sv */
`timescale 1ns / 1ps

module sfqm_front import sfqm_pkg::*; #(
  parameter int TAPS          = TAPS_DEF,
  parameter int QUARTER_DELAY = QUARTER_DELAY_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // Configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [MASK_BITS-1:0]          coef_sign_mask_i,
  // Queue write side
  output logic                          push_o,
  output q_entry_t                      push_data_o,
  input  q_status_t                     q_status_i
);

  localparam int IDX_W    = $clog2(TAPS);
  localparam int ACC_W    = SAMPLE_BITS + $clog2(TAPS) + 1;
  localparam int DIV_SH   = ACC_W + 3;
  localparam int PROD_W   = ACC_W + DIV_SH;
  localparam int RES_W    = ACC_W + 3;
  localparam int QW       = (ACC_W + 1 > FILT_BITS + 1) ? ACC_W + 1 : FILT_BITS + 1;
  localparam logic [DIV_SH-1:0] Recip = DIV_SH'((64'd1 << DIV_SH) / 64'd6);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_ACC  = 6'b000010,
    F_ABS  = 6'b000100,
    F_MUL  = 6'b001000,
    F_FIX  = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_e;

  front_state_e                state_q, state_d;
  logic [MASK_BITS-1:0]        mask_q;
  logic signed [SAMPLE_BITS-1:0] win_q [TAPS];
  logic signed [FILT_BITS-1:0] hist_q [QUARTER_DELAY];
  logic [IDX_W-1:0]            idx_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic [ACC_W-1:0]            abs_q;
  logic                        neg_q;
  logic [PROD_W-1:0]           prod_q;
  logic signed [FILT_BITS-1:0] cur_q;

  logic                        accept;
  logic [TAPS-1:0]             neg_mask;
  logic signed [ACC_W-1:0]     term;
  logic [ACC_W-1:0]            q0;
  logic [RES_W-1:0]            rem6;
  logic [ACC_W-1:0]            qfix;
  logic [QW-1:0]               qu;
  logic signed [QW-1:0]        qs;
  logic signed [FILT_BITS-1:0] qsat;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != F_IDLE);
  assign cfg_ready_o = 1'b1;

  // Per-tap negate flags; taps past the mask are always plus one
  for (genvar g = 0; g < TAPS; g++) begin : g_neg
    if (g < MASK_BITS) begin : g_in
      assign neg_mask[g] = mask_q[g];
    end else begin : g_out
      assign neg_mask[g] = 1'b0;
    end
  end

  // One tap term per cycle
  always_comb begin
    term = ACC_W'(win_q[idx_q]);
    if (neg_mask[idx_q]) begin
      term = -term;
    end
  end

  // Divide by six: reciprocal estimate, then one correction
  always_comb begin
    q0   = prod_q[PROD_W-1:DIV_SH];
    rem6 = RES_W'(abs_q) - ((RES_W'(q0) << 2) + (RES_W'(q0) << 1));
    qfix = (rem6 >= RES_W'(6)) ? q0 + ACC_W'(1) : q0;
    qu   = QW'(qfix);
    qs   = neg_q ? -$signed(qu) : $signed(qu);
    if (qs > QW'(FILT_MAX)) begin
      qsat = FILT_BITS'(FILT_MAX);
    end else if (qs < QW'(FILT_MIN)) begin
      qsat = FILT_BITS'(FILT_MIN);
    end else begin
      qsat = FILT_BITS'(qs);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_ACC;
      end
      F_ACC: begin
        if (idx_q == IDX_W'(TAPS - 1)) state_d = F_ABS;
      end
      F_ABS:  state_d = F_MUL;
      F_MUL:  state_d = F_FIX;
      F_FIX:  state_d = F_PUSH;
      F_PUSH: begin
        if (!q_status_i.full) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_o          = (state_q == F_PUSH) && !q_status_i.full;
  assign push_data_o.cur = cur_q;
  assign push_data_o.old = hist_q[QUARTER_DELAY-1];

  // Control, mask, sample window and filtered history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mask_q  <= MASK_RESET;
      idx_q   <= '0;
      for (int i = 0; i < TAPS; i++) win_q[i] <= '0;
      for (int i = 0; i < QUARTER_DELAY; i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= coef_sign_mask_i;
      end
      if (accept) begin
        win_q[0] <= sample_i;
        for (int i = 1; i < TAPS; i++) win_q[i] <= win_q[i-1];
        idx_q <= '0;
      end else if (state_q == F_ACC) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (push_o) begin
        hist_q[0] <= cur_q;
        for (int i = 1; i < QUARTER_DELAY; i++) hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= '0;
    end else if (state_q == F_ACC) begin
      acc_q <= acc_q + term;
    end
    if (state_q == F_ABS) begin
      neg_q <= acc_q[ACC_W-1];
      abs_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    end
    if (state_q == F_MUL) begin
      prod_q <= PROD_W'(abs_q) * PROD_W'(Recip);
    end
    if (state_q == F_FIX) begin
      cur_q <= qsat;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == F_ACC && idx_q == '0))
    else $error("front: accepted sample did not start accumulation");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PUSH && q_status_i.full) |=> state_q == F_PUSH)
    else $error("front: left push state while queue full");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_ACC) |-> (32'(idx_q) < TAPS))
    else $error("front: tap index out of range");

endmodule

/* hw/rtl/sfqm_queue.sv */
`timescale 1ns / 1ps

module sfqm_queue import sfqm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  push_data_i,
  input  logic      pop_i,
  output q_entry_t  pop_data_o,
  output q_status_t status_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer wrap for any depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue: pop while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= QUEUE_DEPTH)
    else $error("queue: count out of range");

endmodule

/* hw/rtl/sfqm_back.sv */
`timescale 1ns / 1ps

module sfqm_back import sfqm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Queue read side
  output logic                        pop_o,
  input  q_entry_t                    pop_data_i,
  input  q_status_t                   q_status_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FILT_BITS-1:0] filtered_o,
  output logic [MAG_BITS-1:0]         magnitude_o
);

  localparam int CNT_W = $clog2(ROOT_STEPS);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQ   = 4'b0010,
    B_ROOT = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

  back_state_e                 state_q, state_d;
  logic [CNT_W-1:0]            cnt_q;
  logic signed [FILT_BITS-1:0] cur_q, old_q;
  logic [SQ_BITS-1:0]          rad_q;
  logic [REM_BITS-1:0]         rem_q;
  logic [ROOT_BITS-1:0]        root_q;
  logic                        out_valid_q;
  logic signed [FILT_BITS-1:0] filt_q;
  logic [MAG_BITS-1:0]         mag_q;

  logic signed [SQ_BITS-1:0]   sq_cur, sq_old;
  logic [REM_BITS+1:0]         rem_sh, trial;
  logic                        take;
  logic                        load_out;
  logic [MAG_BITS-1:0]         mag_sat;

  assign pop_o    = (state_q == B_IDLE) && !q_status_i.empty;
  assign take     = out_valid_q && !out_stall_i;
  assign load_out = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);

  // Squares: current value squared on pop, old value squared in the square state
  assign sq_cur = SQ_BITS'(pop_data_i.cur) * SQ_BITS'(pop_data_i.cur);
  assign sq_old = SQ_BITS'(old_q) * SQ_BITS'(old_q);

  // One root bit per step
  assign rem_sh = {rem_q, rad_q[SQ_BITS-1 -: 2]};
  assign trial  = {(REM_BITS - ROOT_BITS)'(0), root_q, 2'b01};

  assign mag_sat = (root_q > ROOT_BITS'(MAG_MAX)) ? MAG_BITS'(MAG_MAX) : MAG_BITS'(root_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (pop_o) state_d = B_SQ;
      B_SQ:   state_d = B_ROOT;
      B_ROOT: if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = B_DONE;
      B_DONE: if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_SQ) cnt_q <= '0;
      else if (state_q == B_ROOT) cnt_q <= cnt_q + CNT_W'(1);
      if (load_out) out_valid_q <= 1'b1;
      else if (take) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_data_i.cur;
      old_q <= pop_data_i.old;
      rad_q <= $unsigned(sq_cur);
    end
    if (state_q == B_SQ) begin
      rad_q  <= rad_q + $unsigned(sq_old);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == B_ROOT) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= REM_BITS'(rem_sh - trial);
        root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= REM_BITS'(rem_sh);
        root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (load_out) begin
      filt_q <= cur_q;
      mag_q  <= mag_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;
  assign magnitude_o = mag_q;

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == B_SQ)
    else $error("back: pop did not start squaring");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE && out_valid_q && out_stall_i) |=> state_q == B_DONE)
    else $error("back: result dropped while output stalled");

  a_root_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == B_ROOT) |-> cnt_q == '0)
    else $error("back: root step count not cleared");

endmodule

/* hw/rtl/sign_fir_quadrature_magnitude_top.sv */
`timescale 1ns / 1ps
// The front accepts a new sample only once the last one is pushed; it adds one tap per cycle,
// the back resolves one square root bit per cycle over 14 steps.
// A two-entry queue between front and back lets each side stall on its own.
// Reset (async, active low) clears the sample window, the filtered history and control,
// and loads the sign mask with 504.

module sign_fir_quadrature_magnitude_top import sfqm_pkg::*; #(
  parameter int TAPS          = TAPS_DEF,
  parameter int QUARTER_DELAY = QUARTER_DELAY_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [MASK_BITS-1:0]          coef_sign_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [FILT_BITS-1:0]   filtered_o,
  output logic [MAG_BITS-1:0]           magnitude_o
);

  logic      push, pop;
  q_entry_t  push_data, pop_data;
  q_status_t q_status;

  // Accumulate, divide, keep history
  sfqm_front #(
    .TAPS          (TAPS),
    .QUARTER_DELAY (QUARTER_DELAY),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .coef_sign_mask_i (coef_sign_mask_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .q_status_i       (q_status)
  );

  // Decoupling queue
  sfqm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Squares, square root, output register
  sfqm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .q_status_i  (q_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .magnitude_o (magnitude_o)
  );

endmodule
